@@ src/fcg_pkg.sv @@
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared widths, constants, types and arithmetic helpers for the Fresnel
// chirp generator.
// ----------------------------------------------------------------------------
package fcg_pkg;

   // Block configuration
   localparam int MAX_DIM    = 4096;
   localparam int AMP_BITS   = 16;
   localparam int PHASE_BITS = 32;

   // Field widths
   localparam int IDX_W    = 12;
   localparam int CENTRE_W = 13;
   localparam int COEF_W   = 32;
   localparam int DIFF_W   = IDX_W + 2;
   localparam int SQ_W     = 2 * CENTRE_W + 1;
   localparam int PROD_W   = 40;
   localparam int ANGLE_W  = 32;
   localparam int ZW       = ANGLE_W + 1;
   localparam int XW       = 34;

   localparam int REQ_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((2 * AMP_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_DIM - 1);

   // Phase precision: only the top bits of the turn fraction are kept
   localparam int ANGLE_KEEP = (PHASE_BITS < ANGLE_W) ? PHASE_BITS : ANGLE_W;
   localparam logic [ANGLE_W-1:0] ANGLE_MASK =
      ANGLE_W'(~((64'd1 << (ANGLE_W - ANGLE_KEEP)) - 64'd1));

   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'd1 << (ANGLE_W - 2));
   localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'd1 << (ANGLE_W - 1));

   // CORDIC
   localparam int CORDIC_ITERS    = 24;
   localparam int ITERS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;

   localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

   // arctan(2^-i) in turns, 2^32 per turn
   localparam logic signed [ZW-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
      33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
      33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
      33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81
   };

   // Output rounding to Q1.(AMP_BITS-1)
   localparam int AMP_SHIFT = 31 - AMP_BITS;
   localparam logic signed [XW+1:0] AMP_RND = (XW+2)'(64'd1 << (AMP_SHIFT - 1));
   localparam logic signed [XW+1:0] AMP_LIM = (XW+2)'((64'd1 << (AMP_BITS - 1)) - 64'd1);

   // Register map
   typedef enum logic [1:0] {
      CSR_CENTRE_X = 2'd0,
      CSR_CENTRE_Y = 2'd1,
      CSR_COEF_X   = 2'd2,
      CSR_COEF_Y   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CENTRE_W-1:0] centre_x;
      logic [CENTRE_W-1:0] centre_y;
      logic [COEF_W-1:0]   coef_x;
      logic [COEF_W-1:0]   coef_y;
   } csr_regs_type;

   typedef struct packed {
      logic signed [ZW-1:0] z;
      logic                 flip;
   } phase_word_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_vec_type;

   // One CORDIC rotation step, shifts are floor (arithmetic)
   function automatic cordic_vec_type cordic_iter(input cordic_vec_type v, input int i);
      cordic_vec_type       r;
      logic signed [XW-1:0] sx;
      logic signed [XW-1:0] sy;
      sx = v.x >>> i;
      sy = v.y >>> i;
      if (!v.z[ZW-1]) begin
         r.x = v.x - sy;
         r.y = v.y + sx;
         r.z = v.z - ATAN_TURNS[i];
      end else begin
         r.x = v.x + sy;
         r.y = v.y - sx;
         r.z = v.z + ATAN_TURNS[i];
      end
      return r;
   endfunction

   // Round half up and saturate symmetrically
   function automatic logic [AMP_BITS-1:0] to_amp(input logic signed [XW:0] v);
      logic signed [XW+1:0] t;
      logic signed [XW+1:0] r;
      t = v + AMP_RND;
      r = t >>> AMP_SHIFT;
      if (r > AMP_LIM) begin
         r = AMP_LIM;
      end else if (r < -AMP_LIM) begin
         r = -AMP_LIM;
      end
      return r[AMP_BITS-1:0];
   endfunction

endpackage

@@ src/fcg_csr.sv @@
// ----------------------------------------------------------------------------
// fcg_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module fcg_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fcg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fcg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fcg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output fcg_pkg::csr_regs_type            regs
);

   fcg_pkg::csr_regs_type regs_ff;
   fcg_pkg::csr_index_type index;
   logic                   write_en;

   assign index      = fcg_pkg::csr_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else if (write_en) begin
         case (index)
            fcg_pkg::CSR_CENTRE_X: begin
               regs_ff.centre_x <= csr_pwdata[fcg_pkg::CENTRE_W-1:0];
            end
            fcg_pkg::CSR_CENTRE_Y: begin
               regs_ff.centre_y <= csr_pwdata[fcg_pkg::CENTRE_W-1:0];
            end
            fcg_pkg::CSR_COEF_X: begin
               regs_ff.coef_x <= csr_pwdata[fcg_pkg::COEF_W-1:0];
            end
            fcg_pkg::CSR_COEF_Y: begin
               regs_ff.coef_y <= csr_pwdata[fcg_pkg::COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         fcg_pkg::CSR_CENTRE_X: csr_prdata = fcg_pkg::CSR_DATA_W'(regs_ff.centre_x);
         fcg_pkg::CSR_CENTRE_Y: csr_prdata = fcg_pkg::CSR_DATA_W'(regs_ff.centre_y);
         fcg_pkg::CSR_COEF_X:   csr_prdata = fcg_pkg::CSR_DATA_W'(regs_ff.coef_x);
         fcg_pkg::CSR_COEF_Y:   csr_prdata = fcg_pkg::CSR_DATA_W'(regs_ff.coef_y);
         default:               csr_prdata = '0;
      endcase
   end

endmodule

@@ src/fcg_phase.sv @@
// ----------------------------------------------------------------------------
// fcg_phase
// Four-stage phase pipeline: centre offset, square, coefficient multiply,
// sum to a turn fraction and fold into the right half plane.
// ----------------------------------------------------------------------------
module fcg_phase (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         ce,
   input  logic                         in_valid,
   input  logic [fcg_pkg::IDX_W-1:0]    in_col,
   input  logic [fcg_pkg::IDX_W-1:0]    in_row,
   input  fcg_pkg::csr_regs_type        regs,
   output logic                         out_valid,
   output fcg_pkg::phase_word_type      out_word
);

   logic [3:0] valid_ff;

   logic [fcg_pkg::IDX_W-1:0]           col_clamp, row_clamp;
   logic signed [fcg_pkg::DIFF_W-1:0]   dx_in, dy_in, dx_ff, dy_ff;
   logic signed [2*fcg_pkg::DIFF_W-1:0] sqx_full, sqy_full;
   logic [fcg_pkg::SQ_W-1:0]            sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [fcg_pkg::SQ_W+fcg_pkg::COEF_W-1:0] px_full, py_full;
   logic [fcg_pkg::PROD_W-1:0]          px_in, py_in, px_ff, py_ff;
   logic [fcg_pkg::PROD_W-1:0]          sum;
   logic [fcg_pkg::ANGLE_W-1:0]         angle;
   logic signed [fcg_pkg::ZW-1:0]       z_raw;
   fcg_pkg::phase_word_type             word_in, word_ff;

   // stage 1: distance from centre in half pixels
   always_comb begin
      col_clamp = (in_col > fcg_pkg::IDX_MAX) ? fcg_pkg::IDX_MAX : in_col;
      row_clamp = (in_row > fcg_pkg::IDX_MAX) ? fcg_pkg::IDX_MAX : in_row;
      dx_in = $signed({1'b0, col_clamp, 1'b0}) - $signed({1'b0, regs.centre_x});
      dy_in = $signed({1'b0, row_clamp, 1'b0}) - $signed({1'b0, regs.centre_y});
   end

   // stage 2: square
   always_comb begin
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      sqx_in   = sqx_full[fcg_pkg::SQ_W-1:0];
      sqy_in   = sqy_full[fcg_pkg::SQ_W-1:0];
   end

   // stage 3: scale by coefficient; only the low 40 bits reach the phase
   always_comb begin
      px_full = sqx_ff * regs.coef_x;
      py_full = sqy_ff * regs.coef_y;
      px_in   = px_full[fcg_pkg::PROD_W-1:0];
      py_in   = py_full[fcg_pkg::PROD_W-1:0];
   end

   // stage 4: turn fraction, folded to +-quarter turn with a sign flip
   always_comb begin
      sum   = px_ff + py_ff;
      angle = sum[fcg_pkg::PROD_W-1 -: fcg_pkg::ANGLE_W] & fcg_pkg::ANGLE_MASK;
      z_raw = $signed({angle[fcg_pkg::ANGLE_W-1], angle});
      word_in.z    = z_raw;
      word_in.flip = 1'b0;
      if (z_raw > fcg_pkg::Z_QUARTER) begin
         word_in.z    = z_raw - fcg_pkg::Z_HALF;
         word_in.flip = 1'b1;
      end else if (z_raw < -fcg_pkg::Z_QUARTER) begin
         word_in.z    = z_raw + fcg_pkg::Z_HALF;
         word_in.flip = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_word  = word_ff;

endmodule

@@ src/fcg_cordic.sv @@
// ----------------------------------------------------------------------------
// fcg_cordic
// Pipelined rotation-mode CORDIC, two micro-rotations per register stage.
// ----------------------------------------------------------------------------
module fcg_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  fcg_pkg::phase_word_type       in_word,
   output logic                          out_valid,
   output logic signed [fcg_pkg::XW-1:0] out_x,
   output logic signed [fcg_pkg::XW-1:0] out_y,
   output logic                          out_flip
);

   localparam int N = fcg_pkg::CORDIC_STAGES;

   logic [N-1:0]           valid_ff;
   logic [N-1:0]           flip_ff;
   fcg_pkg::cordic_vec_type vec_ff [N];
   fcg_pkg::cordic_vec_type vec_in [N];
   fcg_pkg::cordic_vec_type vec_init;

   always_comb begin
      vec_init.x = fcg_pkg::CORDIC_GAIN;
      vec_init.y = '0;
      vec_init.z = in_word.z;
   end

   always_comb begin
      fcg_pkg::cordic_vec_type v;
      for (int k = 0; k < N; k++) begin
         v = (k == 0) ? vec_init : vec_ff[(k == 0) ? 0 : k - 1];
         for (int j = 0; j < fcg_pkg::ITERS_PER_STAGE; j++) begin
            v = fcg_pkg::cordic_iter(v, k * fcg_pkg::ITERS_PER_STAGE + j);
         end
         vec_in[k] = v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ce) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         flip_ff <= {flip_ff[N-2:0], in_word.flip};
         for (int k = 0; k < N; k++) begin
            vec_ff[k] <= vec_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_flip  = flip_ff[N-1];
   assign out_x     = vec_ff[N-1].x;
   assign out_y     = vec_ff[N-1].y;

endmodule

@@ src/fresnel_chirp_generator.sv @@
// ----------------------------------------------------------------------------
// fresnel_chirp_generator
// Fresnel quadratic-phase kernel: one complex propagator sample per pixel.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while req_tready is high and returns cos
// and -sin of 2*pi*(coef_x*dx^2 + coef_y*dy^2), Q1.15, one result word per
// pixel in input order. Throughput is one word per cycle unless the output
// stalls; each word passes 4 phase stages, 12 CORDIC stages of two
// micro-rotations each and one output register. A two-entry output register
// and skid stage keep req_tready a registered signal: the pipeline only
// halts once both entries are full. Write the configuration while idle.
module fresnel_chirp_generator (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fcg_pkg::REQ_TDATA_W-1:0]   req_tdata,   // col_index, row_index
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fcg_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // real_part, imag_part
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fcg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fcg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fcg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   fcg_pkg::csr_regs_type          regs;
   fcg_pkg::phase_word_type        phase_word;
   logic                           ce;
   logic                           phase_valid;
   logic                           cordic_valid;
   logic signed [fcg_pkg::XW-1:0]  cordic_x, cordic_y;
   logic                           cordic_flip;
   logic signed [fcg_pkg::XW:0]    x_ext, y_ext, real_v, imag_v;
   logic [fcg_pkg::RSP_TDATA_W-1:0] push_data;
   logic                           push, take;

   logic                           out_valid_ff, skid_valid_ff;
   logic [fcg_pkg::RSP_TDATA_W-1:0] out_data_ff, skid_data_ff;

   // pipeline advances while the skid entry is free
   assign ce         = ~skid_valid_ff;
   assign req_tready = ce;

   fcg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   fcg_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_tvalid),
      .in_col    (req_tdata[fcg_pkg::IDX_W-1:0]),
      .in_row    (req_tdata[2*fcg_pkg::IDX_W-1:fcg_pkg::IDX_W]),
      .regs      (regs),
      .out_valid (phase_valid),
      .out_word  (phase_word)
   );

   fcg_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (phase_valid),
      .in_word   (phase_word),
      .out_valid (cordic_valid),
      .out_x     (cordic_x),
      .out_y     (cordic_y),
      .out_flip  (cordic_flip)
   );

   // undo the half-turn fold, negate sine, round to output format
   always_comb begin
      x_ext  = cordic_x;
      y_ext  = cordic_y;
      real_v = cordic_flip ? -x_ext : x_ext;
      imag_v = cordic_flip ? y_ext : -y_ext;
      push_data = fcg_pkg::RSP_TDATA_W'({fcg_pkg::to_amp(imag_v), fcg_pkg::to_amp(real_v)});
   end

   assign push = ce & cordic_valid;
   assign take = out_valid_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ src/fcg_checker.sv @@
// ----------------------------------------------------------------------------
// fcg_checker
// Port-level checks for the Fresnel chirp generator, bound to the top level.
// ----------------------------------------------------------------------------
module fcg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [fcg_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              csr_pready
);

   localparam int A = fcg_pkg::AMP_BITS;
   localparam logic [A-1:0] AMP_MIN = {1'b1, {(A-1){1'b0}}};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed or vanished");

   // saturation is symmetric: the most negative code never appears
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[A-1:0] != AMP_MIN && rsp_tdata[2*A-1:A] != AMP_MIN)
      else $error("output hit the most negative code");

   // unit-magnitude sample cannot be zero in both parts
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[A-1:0] != '0 || rsp_tdata[2*A-1:A] != '0)
      else $error("sample with zero magnitude");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("config port not ready");

endmodule

bind fresnel_chirp_generator fcg_checker u_fcg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

@@ dv/chirp_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chirp_check_pkg
// Sample predictor and in-order result store for the chirp generator bench.
// The predictor keeps its own copy of the centre and coefficient registers,
// works the phase out in 64-bit integers and runs the fixed-iteration
// rotation to get the expected Q1.15 cosine and negated sine.
// ----------------------------------------------------------------------------
package chirp_check_pkg;
   import fcg_pkg::*;

   typedef struct packed {
      logic [AMP_BITS-1:0] re;
      logic [AMP_BITS-1:0] im;
   } iq_sample_type;

   localparam int     ROTATIONS = 24;
   localparam longint GAIN_Q30  = 652032874;

   // arctan(2^-i) in turns, 2^32 per turn
   localparam longint ARCTAN_Q32 [ROTATIONS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   class chirp_scoreboard;
      int unsigned     centre_x;
      int unsigned     centre_y;
      longint unsigned coef_x;
      longint unsigned coef_y;
      iq_sample_type   awaited_samples[$];
      int              mismatches;
      int              samples_checked;

      function new();
         centre_x        = 0;
         centre_y        = 0;
         coef_x          = 0;
         coef_y          = 0;
         mismatches      = 0;
         samples_checked = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_CENTRE_X: centre_x = value[CENTRE_W-1:0];
            CSR_CENTRE_Y: centre_y = value[CENTRE_W-1:0];
            CSR_COEF_X:   coef_x   = value[COEF_W-1:0];
            CSR_COEF_Y:   coef_y   = value[COEF_W-1:0];
            default:      ;
         endcase
      endfunction

      function int outstanding();
         return awaited_samples.size();
      endfunction

      // round half up to Q1.(AMP_BITS-1), symmetric clamp
      function logic [AMP_BITS-1:0] to_fixed(longint v);
         longint lim;
         longint r;
         lim = (64'sd1 <<< (AMP_BITS - 1)) - 64'sd1;
         r   = (v + (64'sd1 <<< (30 - AMP_BITS))) >>> (31 - AMP_BITS);
         if (r > lim) begin
            r = lim;
         end else if (r < -lim) begin
            r = -lim;
         end
         return r[AMP_BITS-1:0];
      endfunction

      function void note_pixel(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row);
         longint          dx, dy, z, cx, cy, sx, sy;
         longint unsigned sum, ph, ang;
         bit              flip;
         iq_sample_type   s;
         dx  = 2 * longint'((col > MAX_DIM - 1) ? MAX_DIM - 1 : col) - longint'(centre_x);
         dy  = 2 * longint'((row > MAX_DIM - 1) ? MAX_DIM - 1 : row) - longint'(centre_y);
         sum = unsigned'(dx * dx) * coef_x + unsigned'(dy * dy) * coef_y;
         ph  = (sum >> (40 - PHASE_BITS)) & ((64'd1 << PHASE_BITS) - 64'd1);
         if (PHASE_BITS <= 32) begin
            ang = (ph << (32 - PHASE_BITS)) & 64'hFFFF_FFFF;
         end else begin
            ang = ph >> (PHASE_BITS - 32);
         end
         z = longint'(ang);
         if (z >= 64'sd2147483648) begin
            z -= 64'sd4294967296;
         end
         // fold into the right half plane, negate the vector afterwards
         flip = 1'b0;
         if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            flip = 1'b1;
         end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            flip = 1'b1;
         end
         cx = GAIN_Q30;
         cy = 0;
         for (int i = 0; i < ROTATIONS; i++) begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (z >= 0) begin
               cx -= sy;
               cy += sx;
               z  -= ARCTAN_Q32[i];
            end else begin
               cx += sy;
               cy -= sx;
               z  += ARCTAN_Q32[i];
            end
         end
         if (flip) begin
            cx = -cx;
            cy = -cy;
         end
         s.re = to_fixed(cx);
         s.im = to_fixed(-cy);
         awaited_samples.push_back(s);
      endfunction

      function void check_sample(logic [AMP_BITS-1:0] re, logic [AMP_BITS-1:0] im);
         iq_sample_type want;
         if (awaited_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result word with nothing pending: real %0d imag %0d",
                        $signed(re), $signed(im));
            end
            return;
         end
         want = awaited_samples.pop_front();
         samples_checked++;
         if (want.re !== re || want.im !== im) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at sample %0d: real exp %0d got %0d, imag exp %0d got %0d",
                        samples_checked, $signed(want.re), $signed(re),
                        $signed(want.im), $signed(im));
            end
         end
      endfunction
   endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for the Fresnel chirp generator.
// Directed pixels hit the quadrant folds, saturation and an off-grid centre,
// then about a thousand random pixels run under many register settings with
// random idling on both sides; every result word is checked in order.
// ----------------------------------------------------------------------------
module tb;
   import fcg_pkg::*;
   import chirp_check_pkg::*;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // col_index, row_index
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // real_part, imag_part
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   chirp_scoreboard sb;
   int tx_idle_pct   = 14;
   int rx_stall_pct  = 59;
   int pixels_sent   = 0;
   int settings_used = 1;
   int csr_errors    = 0;

   always #5 clock = ~clock;

   fresnel_chirp_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // result side: check on each accepted word, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_sample(rsp_tdata[AMP_BITS-1:0], rsp_tdata[2*AMP_BITS-1:AMP_BITS]);
      end
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({row, col});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(col, row);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // setup, access, then a return to bus idle so the next setup never collides
   task automatic csr_access(input csr_index_type idx, input logic write,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write_verify(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] got;
      csr_access(idx, 1'b1, value, got);
      sb.set_reg(idx, value);
      csr_access(idx, 1'b0, '0, got);
      if (got !== value) begin
         csr_errors++;
         $display("register %s reads %h, wrote %h", idx.name(), got, value);
      end
   endtask

   task automatic load_settings(input logic [12:0] cxh, input logic [12:0] cyh,
                                input logic [31:0] kx, input logic [31:0] ky);
      csr_write_verify(CSR_CENTRE_X, 32'(cxh));
      csr_write_verify(CSR_CENTRE_Y, 32'(cyh));
      csr_write_verify(CSR_COEF_X, kx);
      csr_write_verify(CSR_COEF_Y, ky);
      settings_used++;
   endtask

   function automatic logic [12:0] rand_centre();
      case ($urandom_range(5))
         0:       return 13'd0;
         1:       return 13'd8190;
         2:       return 13'd8191;
         3:       return 13'(4094 + $urandom_range(2));
         default: return 13'($urandom_range(8191));
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'($urandom_range(4095));
         3:       return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // mostly uniform, some edges and some pixels close to the centre
   function automatic logic [IDX_W-1:0] rand_index(input logic [12:0] centre_half);
      int v;
      case ($urandom_range(9))
         0:       return '0;
         1:       return IDX_W'(MAX_DIM - 1);
         2, 3: begin
            v = int'(centre_half / 2) + int'($urandom_range(8)) - 4;
            return (v < 0) ? '0 : (v > MAX_DIM - 1) ? IDX_W'(MAX_DIM - 1) : IDX_W'(v);
         end
         default: return IDX_W'($urandom_range(MAX_DIM - 1));
      endcase
   endfunction

   initial begin
      logic [12:0] cxh;
      logic [12:0] cyh;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: zero phase everywhere, cosine saturates
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      wait_idle();

      // centre beyond the last half pixel, largest coefficients
      load_settings(13'd8191, 13'd8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd2048, 12'd17);
      send_pixel(12'd1, 12'd4094);
      wait_idle();

      // centre at zero: index 8 gives a phase word equal to the coefficient
      load_settings(13'd0, 13'd0, 32'h4000_0000, 32'h8000_0000);
      send_pixel(12'd8, 12'd0);
      send_pixel(12'd0, 12'd8);
      send_pixel(12'd8, 12'd8);
      send_pixel(12'd0, 12'd0);
      wait_idle();

      // one lsb past the quarter-turn folds either side
      load_settings(13'd0, 13'd0, 32'h4000_0001, 32'h7FFF_FFFE);
      send_pixel(12'd8, 12'd0);
      send_pixel(12'd0, 12'd8);
      send_pixel(12'd8, 12'd8);
      send_pixel(12'd4, 12'd4);
      wait_idle();

      // phase word all ones, and a row sitting exactly on its centre
      load_settings(13'd0, 13'd8190, 32'hFFFF_FFFF, 32'h0000_0001);
      send_pixel(12'd8, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd1, 12'd2048);
      wait_idle();

      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct  = (mode == 0) ? 14 : (mode == 1) ? 59 : 0;
         rx_stall_pct = (mode == 0) ? 59 : (mode == 1) ? 14 : 0;
         for (int p = 0; p < 4; p++) begin
            cxh = rand_centre();
            cyh = rand_centre();
            load_settings(cxh, cyh, rand_coef(), rand_coef());
            repeat (82) send_pixel(rand_index(cxh), rand_index(cyh));
            wait_idle();
         end
      end

      repeat (40) @(posedge clock);
      $display("Ran %0d pixel words over %0d register settings, incl. folds and saturation",
               pixels_sent, settings_used);
      $display("%0d samples compared, %0d mismatches, %0d register readback errors",
               sb.samples_checked, sb.mismatches, csr_errors);
      if (sb.mismatches == 0 && csr_errors == 0 && sb.outstanding() == 0) begin
         $display("PASS fresnel_chirp_generator");
      end else begin
         $display("FAIL fresnel_chirp_generator");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d samples still pending", sb.outstanding());
      $display("FAIL fresnel_chirp_generator");
      $finish;
   end

endmodule
